>>> rtl/utf16_to_utf8_transcoder_assert.svh
// assertion macros used by the transcoder back end
`ifndef UTF16_TO_UTF8_TRANSCODER_ASSERT_SVH
`define UTF16_TO_UTF8_TRANSCODER_ASSERT_SVH
`ifndef ASSERT_OFF
`define U2U8_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");
`define U2U8_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define U2U8_ASSERT_ALWAYS(label, clk, rst, cond)
`define U2U8_ASSERT_IMPLY(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/u2u8_pkg.sv
// types, constants and encode helper for the utf16 to utf8 transcoder
`timescale 1ns / 1ps
`default_nettype none
package u2u8_pkg;

  localparam int QDEPTH = 2;
  localparam int QPTW   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNTW  = $clog2(QDEPTH + 1);
  localparam int MAXB   = 6;

  localparam logic [5:0] HIGH_TAG = 6'b110110;
  localparam logic [5:0] LOW_TAG  = 6'b110111;
  localparam logic [7:0] LEAD2    = 8'hC0;
  localparam logic [7:0] LEAD3    = 8'hE0;
  localparam logic [7:0] LEAD4    = 8'hF0;
  localparam logic [7:0] CONT     = 8'h80;
  localparam logic [15:0] MAX1    = 16'h007F;
  localparam logic [15:0] MAX2    = 16'h07FF;
  localparam logic [20:0] SUPP_BASE = 21'h010000;

  typedef struct packed {
    logic [2:0][7:0] b;
    logic [1:0]      n;
  } bmp_t;

  typedef struct packed {
    logic [MAXB-1:0][7:0] b;
    logic [2:0]           cnt;
    logic                 last;
  } job_t;

  function automatic bmp_t enc_bmp(input logic [15:0] u);
    bmp_t r;
    r.b = '0;
    if (u <= MAX1) begin
      r.n    = 2'd1;
      r.b[0] = u[7:0];
    end else if (u <= MAX2) begin
      r.n    = 2'd2;
      r.b[0] = LEAD2 | {3'b000, u[10:6]};
      r.b[1] = CONT | {2'b00, u[5:0]};
    end else begin
      r.n    = 2'd3;
      r.b[0] = LEAD3 | {4'b0000, u[15:12]};
      r.b[1] = CONT | {2'b00, u[11:6]};
      r.b[2] = CONT | {2'b00, u[5:0]};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/u2u8_front.sv
// front end: accepts code units, pairs surrogates, builds byte jobs
`timescale 1ns / 1ps
`default_nettype none
module u2u8_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [15:0]    code_unit,
  input  wire logic           string_last,
  input  wire logic           q_full,
  output logic                q_push,
  output u2u8_pkg::job_t      q_data
);
  import u2u8_pkg::*;

  logic       held_valid, held_valid_next;
  logic [9:0] held_high_bits, held_high_bits_next;
  logic       is_high, is_low, accept;
  logic [20:0] cp;
  bmp_t       enc_held, enc_unit;

  assign is_high  = code_unit[15:10] == HIGH_TAG;
  assign is_low   = code_unit[15:10] == LOW_TAG;
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign cp       = {1'b0, held_high_bits, code_unit[9:0]} + SUPP_BASE;
  assign enc_held = enc_bmp({HIGH_TAG, held_high_bits});
  assign enc_unit = enc_bmp(code_unit);

  always_comb begin
    q_data              = '0;
    q_data.last         = string_last;
    held_valid_next     = held_valid;
    held_high_bits_next = held_high_bits;
    if (held_valid && is_low) begin
      q_data.b[0]         = LEAD4 | {5'b00000, cp[20:18]};
      q_data.b[1]         = CONT | {2'b00, cp[17:12]};
      q_data.b[2]         = CONT | {2'b00, cp[11:6]};
      q_data.b[3]         = CONT | {2'b00, cp[5:0]};
      q_data.cnt          = 3'd4;
      held_valid_next     = 1'b0;
      held_high_bits_next = '0;
    end else if (held_valid) begin
      q_data.b[2:0]       = enc_held.b;
      held_valid_next     = 1'b0;
      held_high_bits_next = '0;
      if (is_high && !string_last) begin
        q_data.cnt          = 3'd3;
        held_valid_next     = 1'b1;
        held_high_bits_next = code_unit[9:0];
      end else begin
        q_data.b[5:3] = enc_unit.b;
        q_data.cnt    = 3'd3 + {1'b0, enc_unit.n};
      end
    end else if (is_high && !string_last) begin
      q_data.cnt          = 3'd0;
      held_valid_next     = 1'b1;
      held_high_bits_next = code_unit[9:0];
    end else begin
      q_data.b[2:0] = enc_unit.b;
      q_data.cnt    = {1'b0, enc_unit.n};
    end
  end

  assign q_push = accept && (q_data.cnt != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid     <= 1'b0;
      held_high_bits <= '0;
    end else if (accept) begin
      held_valid     <= held_valid_next;
      held_high_bits <= held_high_bits_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/u2u8_queue.sv
// short job queue between front and back ends
`timescale 1ns / 1ps
`default_nettype none
module u2u8_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire u2u8_pkg::job_t push_data,
  output logic                full,
  input  wire logic           pop,
  output u2u8_pkg::job_t      pop_data,
  output logic                empty
);
  import u2u8_pkg::*;

  job_t             entries [QDEPTH];
  logic [QPTW-1:0]  wr_ptr, rd_ptr;
  logic [QCNTW-1:0] count;

  assign full     = count == QCNTW'(QDEPTH);
  assign empty    = count == '0;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/u2u8_back.sv
// back end: walks one job a byte at a time onto the output stream
`timescale 1ns / 1ps
`default_nettype none
`include "utf16_to_utf8_transcoder_assert.svh"
module u2u8_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_empty,
  input  wire u2u8_pkg::job_t q_data,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [7:0]          utf8_byte,
  output logic                run_last,
  output logic                string_end
);
  import u2u8_pkg::*;

  job_t       cur;
  logic       cur_valid;
  logic [2:0] idx;
  logic       done, load;

  assign done       = idx == (cur.cnt - 3'd1);
  assign load       = !cur_valid || (out_ready && done);
  assign q_pop      = load && !q_empty;
  assign out_valid  = cur_valid;
  assign utf8_byte  = cur.b[idx];
  assign run_last   = done;
  assign string_end = done && cur.last;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      cur_valid <= !q_empty;
      idx       <= '0;
    end else if (out_ready) begin
      idx <= idx + 3'd1;
    end
  end

  `U2U8_ASSERT_IMPLY(a_idx_in_job, clk, rst, cur_valid, idx < cur.cnt)
  `U2U8_ASSERT_IMPLY(a_job_nonempty, clk, rst, cur_valid, cur.cnt != 3'd0)
  `U2U8_ASSERT_IMPLY(a_end_on_run_last, clk, rst, out_valid && string_end, run_last)

endmodule
`default_nettype wire

>>> rtl/utf16_to_utf8_transcoder.sv
// top level of the utf16 to utf8 transcoder
//
//  channel  dir  payload                         accept
//  s_axis   in   tdata code_unit, tlast last     tvalid & tready
//  m_axis   out  tdata byte, tlast run, tuser    tvalid & tready
//
// one code unit is taken per cycle while the job queue has room
// output runs one byte per cycle while m_axis_tready is high: 1 to 3 bytes per
// bmp unit, 4 per pair, up to 6; the back end serializer sets the sustained rate
// rst is synchronous and clears the held surrogate, queue and output stage
// a stalled output fills the queue, then drops s_axis_tready
`timescale 1ns / 1ps
`default_nettype none
module utf16_to_utf8_transcoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // [15:0] code_unit
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // [7:0] utf8_byte
  output logic             m_axis_tlast,
  output logic             m_axis_tuser   // [0] string_end
);
  import u2u8_pkg::*;

  logic q_push, q_full, q_pop, q_empty;
  job_t push_data, pop_data;

  u2u8_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .code_unit   (s_axis_tdata),
    .string_last (s_axis_tlast),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (push_data)
  );

  u2u8_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  u2u8_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_data     (pop_data),
    .q_pop      (q_pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .utf8_byte  (m_axis_tdata),
    .run_last   (m_axis_tlast),
    .string_end (m_axis_tuser)
  );

endmodule
`default_nettype wire

>>> test/tb_utf16_to_utf8_transcoder.sv
// testbench for the utf16 to utf8 transcoder: directed table and random strings against a predictor
`timescale 1ns / 1ps
module tb_utf16_to_utf8_transcoder;

  localparam int IDLE_LIMIT = 2000;
  localparam int LONG_HOLD  = 200;
  localparam int MAX_ROWS   = 32;
  localparam int RAND_UNITS = 176;

  localparam logic [15:0] HIGH_MIN = 16'hD800;
  localparam logic [15:0] HIGH_MAX = 16'hDBFF;
  localparam logic [15:0] LOW_MIN  = 16'hDC00;
  localparam logic [15:0] LOW_MAX  = 16'hDFFF;

  // bytes left-aligned: first byte in [47:40]
  typedef struct packed {
    logic [47:0] b;
    logic [2:0]  cnt;
  } utf8_run_t;

  typedef struct packed {
    logic [7:0] value;
    logic       run_last;
    logic       string_end;
  } utf8_byte_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  utf16_to_utf8_transcoder dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // predictor state
  logic       held_valid;
  logic [9:0] held_bits;

  utf8_byte_t pending_bytes[$];

  logic       row_typed;
  utf8_run_t  row_bytes;
  logic       no_idle;
  logic       long_hold;
  int         errors;
  int         idle_cycles;
  int         units_accepted;
  int         bytes_checked;
  int         strings_sent;
  int         rand_units;

  logic [15:0] tbl_unit [MAX_ROWS];
  logic        tbl_last [MAX_ROWS];
  logic        tbl_typed[MAX_ROWS];
  utf8_run_t   tbl_bytes[MAX_ROWS];
  int          tbl_rows;

  function automatic utf8_run_t append_code_point(input utf8_run_t r, input logic [20:0] cp);
    logic [31:0] seq;
    logic [2:0]  k;
    if (cp <= 21'h7F) begin
      seq = {cp[7:0], 24'h0};
      k   = 3'd1;
    end else if (cp <= 21'h7FF) begin
      seq = {3'b110, cp[10:6], 2'b10, cp[5:0], 16'h0};
      k   = 3'd2;
    end else if (cp <= 21'hFFFF) begin
      seq = {4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0], 8'h0};
      k   = 3'd3;
    end else begin
      seq = {5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6], 2'b10, cp[5:0]};
      k   = 3'd4;
    end
    r.b   = r.b | ({seq, 16'h0} >> (8 * r.cnt));
    r.cnt = r.cnt + k;
    return r;
  endfunction

  function automatic utf8_run_t transcode_unit(input logic [15:0] unit, input logic last);
    utf8_run_t r;
    logic      is_high;
    logic      is_low;
    r       = '0;
    is_high = unit >= HIGH_MIN && unit <= HIGH_MAX;
    is_low  = unit >= LOW_MIN && unit <= LOW_MAX;
    if (held_valid && is_low) begin
      r          = append_code_point(r, 21'h10000 + {1'b0, held_bits, unit[9:0]});
      held_valid = 1'b0;
    end else begin
      // unpaired held surrogate goes out as is
      if (held_valid) begin
        r          = append_code_point(r, {5'b0, 6'b110110, held_bits});
        held_valid = 1'b0;
      end
      if (is_high && !last) begin
        held_bits  = unit[9:0];
        held_valid = 1'b1;
      end else begin
        r = append_code_point(r, {5'b0, unit});
      end
    end
    return r;
  endfunction

  task automatic add_row(input logic [15:0] unit, input logic last, input logic typed,
                         input int cnt, input logic [47:0] b);
    tbl_unit[tbl_rows]      = unit;
    tbl_last[tbl_rows]      = last;
    tbl_typed[tbl_rows]     = typed;
    tbl_bytes[tbl_rows].b   = b;
    tbl_bytes[tbl_rows].cnt = cnt[2:0];
    tbl_rows++;
  endtask

  task automatic send_unit(input logic [15:0] unit, input logic last, input logic typed,
                           input utf8_run_t bytes);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    repeat (gap) begin
      @(negedge clk);
      s_axis_tvalid = 1'b0;
    end
    @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = unit;
    s_axis_tlast  = last;
    row_typed     = typed;
    row_bytes     = bytes;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic send_random_string();
    logic [15:0] units[$];
    int          tokens;
    tokens = $urandom_range(1, 6);
    repeat (tokens) begin
      case ($urandom_range(0, 9))
        0, 1, 2: units.insert(units.size(), 16'($urandom_range(0, 16'h7F)));
        3:       units.insert(units.size(), 16'($urandom_range(16'h80, 16'h7FF)));
        4: begin
          if ($urandom_range(0, 1))
            units.insert(units.size(), 16'($urandom_range(16'h800, HIGH_MIN - 1)));
          else
            units.insert(units.size(), 16'($urandom_range(LOW_MAX + 1, 16'hFFFF)));
        end
        5, 6: begin
          units.insert(units.size(), 16'($urandom_range(HIGH_MIN, HIGH_MAX)));
          units.insert(units.size(), 16'($urandom_range(LOW_MIN, LOW_MAX)));
        end
        7:       units.insert(units.size(), 16'($urandom_range(LOW_MIN, LOW_MAX)));
        8:       units.insert(units.size(), 16'($urandom_range(HIGH_MIN, HIGH_MAX)));
        default: units.insert(units.size(), 16'($urandom_range(0, 16'hFFFF)));
      endcase
    end
    foreach (units[i]) send_unit(units[i], i == units.size() - 1, 1'b0, '0);
    rand_units += units.size();
    strings_sent++;
  endtask

  always @(posedge clk) begin
    utf8_run_t  r;
    utf8_byte_t want;
    if (rst) begin
      held_valid = 1'b0;
      held_bits  = '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        r = transcode_unit(s_axis_tdata, s_axis_tlast);
        if (row_typed) r = row_bytes;
        units_accepted++;
        for (int i = 0; i < r.cnt; i++) begin
          want.value      = r.b[47 - 8 * i -: 8];
          want.run_last   = i == r.cnt - 1;
          want.string_end = (i == r.cnt - 1) && s_axis_tlast;
          pending_bytes.insert(pending_bytes.size(), want);
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        bytes_checked++;
        if (pending_bytes.size() == 0) begin
          $display("%0t: unexpected byte %02h", $time, m_axis_tdata);
          errors++;
        end else begin
          want = pending_bytes.pop_front();
          if (m_axis_tdata !== want.value) begin
            $display("%0t: utf8_byte expected %02h actual %02h", $time, want.value,
                     m_axis_tdata);
            errors++;
          end
          if (m_axis_tlast !== want.run_last) begin
            $display("%0t: run_last expected %0b actual %0b", $time, want.run_last,
                     m_axis_tlast);
            errors++;
          end
          if (m_axis_tuser !== want.string_end) begin
            $display("%0t: string_end expected %0b actual %0b", $time, want.string_end,
                     m_axis_tuser);
            errors++;
          end
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("utf16_to_utf8_transcoder test failed");
        $finish;
      end
    end
  end

  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 10);
      if (long_hold) begin
        stall     = LONG_HOLD;
        long_hold = 1'b0;
      end
      repeat (stall) begin
        @(negedge clk);
        m_axis_tready = 1'b0;
      end
      @(negedge clk);
      m_axis_tready = 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  initial begin
    logic hold_done;
    rst            = 1'b1;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tlast   = 1'b0;
    row_typed      = 1'b0;
    row_bytes      = '0;
    no_idle        = 1'b0;
    long_hold      = 1'b0;
    hold_done      = 1'b0;
    errors         = 0;
    idle_cycles    = 0;
    units_accepted = 0;
    bytes_checked  = 0;
    strings_sent   = 0;
    rand_units     = 0;
    tbl_rows       = 0;

    // unit, last, typed, byte count, bytes
    add_row(16'h0000, 1'b1, 1'b1, 1, 48'h00_00_00_00_00_00);
    add_row(16'h007F, 1'b0, 1'b1, 1, 48'h7F_00_00_00_00_00);
    add_row(16'h0080, 1'b0, 1'b1, 2, 48'hC2_80_00_00_00_00);
    add_row(16'h07FF, 1'b0, 1'b1, 2, 48'hDF_BF_00_00_00_00);
    add_row(16'h0800, 1'b0, 1'b1, 3, 48'hE0_A0_80_00_00_00);
    add_row(16'hFFFF, 1'b1, 1'b1, 3, 48'hEF_BF_BF_00_00_00);
    // lowest pair
    add_row(16'hD800, 1'b0, 1'b1, 0, 48'h0);
    add_row(16'hDC00, 1'b0, 1'b1, 4, 48'hF0_90_80_80_00_00);
    // highest pair, ending the string
    add_row(16'hDBFF, 1'b0, 1'b1, 0, 48'h0);
    add_row(16'hDFFF, 1'b1, 1'b1, 4, 48'hF4_8F_BF_BF_00_00);
    // lone low, then high at string end
    add_row(16'hDC00, 1'b1, 1'b1, 3, 48'hED_B0_80_00_00_00);
    add_row(16'hD800, 1'b1, 1'b1, 3, 48'hED_A0_80_00_00_00);
    // held high flushed by a plain unit
    add_row(16'hDBFF, 1'b0, 1'b1, 0, 48'h0);
    add_row(16'h0041, 1'b0, 1'b1, 4, 48'hED_AF_BF_41_00_00);
    // held high replaced by another high, then two highs flushed at end
    add_row(16'hD801, 1'b0, 1'b1, 0, 48'h0);
    add_row(16'hDB00, 1'b0, 1'b1, 3, 48'hED_A0_81_00_00_00);
    add_row(16'hD800, 1'b1, 1'b1, 6, 48'hED_AC_80_ED_A0_80);
    // pair closed by string end
    add_row(16'hDBFF, 1'b0, 1'b1, 0, 48'h0);
    add_row(16'hDC00, 1'b1, 1'b1, 4, 48'hF4_8F_B0_80_00_00);
    add_row(16'h1234, 1'b0, 1'b0, 0, 48'h0);
    add_row(16'hA5C3, 1'b1, 1'b0, 0, 48'h0);
    add_row(16'hD7FF, 1'b0, 1'b0, 0, 48'h0);
    add_row(16'hE000, 1'b0, 1'b0, 0, 48'h0);
    add_row(16'h5A5A, 1'b1, 1'b0, 0, 48'h0);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < tbl_rows; i++)
      send_unit(tbl_unit[i], tbl_last[i], tbl_typed[i], tbl_bytes[i]);

    while (rand_units < RAND_UNITS) begin
      no_idle = rand_units >= 70 && rand_units < 120;
      if (!hold_done && rand_units >= 140) begin
        long_hold = 1'b1;
        hold_done = 1'b1;
      end
      send_random_string();
    end
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    no_idle       = 1'b0;

    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d code units in %0d directed rows and %0d random strings", units_accepted,
             tbl_rows, strings_sent);
    $display("%0d utf8 bytes checked, including pairs, lone surrogates and flushes",
             bytes_checked);
    if (errors == 0) begin
      $display("utf16_to_utf8_transcoder test passed");
    end else begin
      $display("utf16_to_utf8_transcoder test failed");
    end
    $finish;
  end

endmodule

>>> utf16_to_utf8_transcoder.f
+incdir+rtl
rtl/u2u8_pkg.sv
rtl/u2u8_front.sv
rtl/u2u8_queue.sv
rtl/u2u8_back.sv
rtl/utf16_to_utf8_transcoder.sv
test/tb_utf16_to_utf8_transcoder.sv
